// ----- hdl/mahs_pkg.sv -----
// Shared types, constants and lookup functions for the MPEG audio header scanner.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package mahs_pkg;

    // Byte counter saturates at this value; the counter is just wide enough to hold it
    localparam int unsigned MAX_SCAN_BYTES = 65536;
    localparam int unsigned COUNT_W        = $clog2(MAX_SCAN_BYTES + 1);

    // Header sync and field check codes
    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] SYNC_MASK   = 8'hF8;
    localparam logic [3:0] RATE_BAD    = 4'hF;
    localparam logic [1:0] FREQ_BAD    = 2'd3;
    localparam logic [1:0] LAYER_NONE  = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd3;

    // Frequency index codes
    localparam logic [1:0] FREQ_44100 = 2'd0;
    localparam logic [1:0] FREQ_48000 = 2'd1;
    localparam logic [1:0] FREQ_32000 = 2'd2;

    // Scan state as seen by the current byte (after any new-buffer clear)
    typedef struct packed {
        logic [23:0]        window;  // oldest byte in bits 23..16
        logic [COUNT_W-1:0] count;
        logic               seen;
    } scan_state_t;

    // One result request
    typedef struct packed {
        logic        found;
        logic [15:0] header_offset;
        logic [1:0]  layer_code;
        logic [3:0]  rate_index;
        logic [1:0]  freq_index;
        logic [1:0]  channel_mode;
        logic [1:0]  mode_extension;
        logic [4:0]  flag_bits;
        logic [1:0]  emphasis_code;
        logic [1:0]  channel_count;
        logic [15:0] sample_rate_hz;
    } result_t;

    // Channel count from the channel mode
    function automatic logic [1:0] chan_count(input logic [1:0] mode);
        logic [1:0] cnt;
        cnt = (mode == MODE_SINGLE) ? 2'd1 : 2'd2;
        return cnt;
    endfunction

    // Sample rate in hertz from the frequency index
    function automatic logic [15:0] sample_rate(input logic [1:0] freq);
        logic [15:0] hz;
        unique case (freq)
            FREQ_44100: hz = 16'd44100;
            FREQ_48000: hz = 16'd48000;
            FREQ_32000: hz = 16'd32000;
            default:    hz = 16'd0;
        endcase
        return hz;
    endfunction

endpackage

// ----- hdl/mahs_window.sv -----
// Sliding three-byte window, saturating byte counter and found mark of the scanner.
// Depends on mahs_pkg for the state struct and counter width.
module mahs_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           data_byte,
    input  logic                 first_byte,
    input  logic                 hit,
    output mahs_pkg::scan_state_t cur_state
);

    logic [23:0]                  window_reg;
    logic [mahs_pkg::COUNT_W-1:0] count_reg;
    logic                         seen_reg;

    logic [23:0]                  window_next;
    logic [mahs_pkg::COUNT_W-1:0] count_next;
    logic                         seen_next;

    // Clear the state ahead of the byte when a new buffer starts
    always_comb
    begin
        if (first_byte)
        begin
            cur_state = '0;
        end
        else
        begin
            cur_state.window = window_reg;
            cur_state.count  = count_reg;
            cur_state.seen   = seen_reg;
        end
    end

    // Shift the byte in, advance the counter until it saturates, hold the found mark
    always_comb
    begin
        window_next = {cur_state.window[15:0], data_byte};
        if (cur_state.count < mahs_pkg::COUNT_W'(mahs_pkg::MAX_SCAN_BYTES))
        begin
            count_next = cur_state.count + mahs_pkg::COUNT_W'(1);
        end
        else
        begin
            count_next = cur_state.count;
        end
        seen_next = cur_state.seen | hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            seen_reg   <= 1'b0;
        end
        else if (take)
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

// ----- hdl/mahs_decode.sv -----
// Header check and field decode for the candidate ending at the current byte.
// Depends on mahs_pkg for the state and result structs and the lookup functions.
module mahs_decode (
    input  mahs_pkg::scan_state_t cur_state,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  hit,
    output logic                  emit,
    output mahs_pkg::result_t     result
);

    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] layer;
    logic [3:0] rate;
    logic [1:0] freq;
    logic [1:0] mode;

    // Split the window into the three older header bytes
    assign b0    = cur_state.window[23:16];
    assign b1    = cur_state.window[15:8];
    assign b2    = cur_state.window[7:0];
    assign layer = b1[2:1];
    assign rate  = b2[7:4];
    assign freq  = b2[3:2];
    assign mode  = data_byte[7:6];

    // First valid header of the buffer
    assign hit = !cur_state.seen
              && (cur_state.count >= mahs_pkg::COUNT_W'(3))
              && (b0 == mahs_pkg::SYNC_BYTE)
              && ((b1 & mahs_pkg::SYNC_MASK) == mahs_pkg::SYNC_MASK)
              && (layer != mahs_pkg::LAYER_NONE)
              && (rate != mahs_pkg::RATE_BAD)
              && (freq != mahs_pkg::FREQ_BAD);

    // Report a header, or a not-found on the last byte of a buffer without one
    assign emit = hit || (last_byte && !cur_state.seen);

    // Build the result; everything is zero for not-found
    always_comb
    begin
        result = '0;
        if (hit)
        begin
            result.found          = 1'b1;
            result.header_offset  = 16'(cur_state.count - mahs_pkg::COUNT_W'(3));
            result.layer_code     = layer;
            result.rate_index     = rate;
            result.freq_index     = freq;
            result.channel_mode   = mode;
            result.mode_extension = data_byte[5:4];
            result.flag_bits      = {data_byte[2], data_byte[3], b2[0], b2[1], b1[0]};
            result.emphasis_code  = data_byte[1:0];
            result.channel_count  = mahs_pkg::chan_count(mode);
            result.sample_rate_hz = mahs_pkg::sample_rate(freq);
        end
    end

endmodule

// ----- hdl/mahs_out.sv -----
// Result register of the scanner: holds one result request until the sink takes it.
// Depends on mahs_pkg for the result struct.
module mahs_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              emit,
    input  mahs_pkg::result_t result,
    input  logic              out_ready,
    output logic              in_ready,
    output logic              out_valid,
    output mahs_pkg::result_t out_result
);

    logic              valid_reg;
    logic              valid_next;
    mahs_pkg::result_t result_reg;
    logic              load;

    // Accept while the register is empty or is being emptied this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready && emit;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ----- hdl/mpeg_audio_header_scanner.sv -----
// MPEG audio header scanner: takes one byte per clock while its input is ready and reports the
// first valid frame header of each buffer, or a not-found result on the buffer's last byte.
// Each byte is checked in the cycle it is accepted against the three bytes held before it,
// and any result lands in a single output register in the following cycle; a new byte is
// accepted every cycle while that register is empty or being read, so sustained rate is one
// byte per clock. The byte counter saturates at 65536; header_offset is the low 16 bits of
// the count minus 3.
// Depends on mahs_pkg, mahs_window, mahs_decode and mahs_out.
module mpeg_audio_header_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [15:0] header_offset,
    output logic [1:0]  layer_code,
    output logic [3:0]  rate_index,
    output logic [1:0]  freq_index,
    output logic [1:0]  channel_mode,
    output logic [1:0]  mode_extension,
    output logic [4:0]  flag_bits,
    output logic [1:0]  emphasis_code,
    output logic [1:0]  channel_count,
    output logic [15:0] sample_rate_hz
);

    mahs_pkg::scan_state_t cur_state;
    mahs_pkg::result_t     result;
    mahs_pkg::result_t     out_result;
    logic                  hit;
    logic                  emit;
    logic                  take;

    assign take = in_valid && in_ready;

    // Window, counter and found mark
    mahs_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .hit        (hit),
        .cur_state  (cur_state)
    );

    // Header check and decode
    mahs_decode u_decode (
        .cur_state (cur_state),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .hit       (hit),
        .emit      (emit),
        .result    (result)
    );

    // Result register
    mahs_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .emit       (emit),
        .result     (result),
        .out_ready  (out_ready),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_result (out_result)
    );

    assign found          = out_result.found;
    assign header_offset  = out_result.header_offset;
    assign layer_code     = out_result.layer_code;
    assign rate_index     = out_result.rate_index;
    assign freq_index     = out_result.freq_index;
    assign channel_mode   = out_result.channel_mode;
    assign mode_extension = out_result.mode_extension;
    assign flag_bits      = out_result.flag_bits;
    assign emphasis_code  = out_result.emphasis_code;
    assign channel_count  = out_result.channel_count;
    assign sample_rate_hz = out_result.sample_rate_hz;

    // A header accepted with this byte shows up as a found result next cycle
    a_hit_to_found: assert property (@(posedge clk) disable iff (!rst_n)
        take && hit |=> out_valid && found)
        else $error("header hit did not produce a found result");

    // A not-found request accepted with this byte shows up next cycle
    a_miss_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        take && emit && !hit |=> out_valid && !found)
        else $error("not-found request lost");

    // A found result carries a legal layer, channel count and rate
    a_found_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> layer_code != 2'd0 && sample_rate_hz != 16'd0
            && (channel_count == 2'd1 || channel_count == 2'd2))
        else $error("found result with illegal fields");

    // A not-found result is all zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> header_offset == 16'd0 && channel_count == 2'd0
            && sample_rate_hz == 16'd0 && flag_bits == 5'd0)
        else $error("not-found result carries nonzero fields");

    // The input side never stalls while the result register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule
